@@ rtl/mexp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Control word layout, sequencer status, operation and condition codes, and
// the microprogram of the exponentiation sequencer.
// ----------------------------------------------------------------------------
package mexp_pkg;

  localparam int PC_W      = 4;
  localparam int OP_W      = 4;
  localparam int COND_W    = 3;
  localparam int DST_W     = 2;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 1'b1;

  localparam logic [OP_W-1:0] OP_NONE     = 4'd0;
  localparam logic [OP_W-1:0] OP_ACCEPT   = 4'd1;
  localparam logic [OP_W-1:0] OP_MUL_RED  = 4'd2;
  localparam logic [OP_W-1:0] OP_MUL_ACC  = 4'd3;
  localparam logic [OP_W-1:0] OP_MUL_SQR  = 4'd4;
  localparam logic [OP_W-1:0] OP_WAIT     = 4'd5;
  localparam logic [OP_W-1:0] OP_NEXT_BIT = 4'd6;
  localparam logic [OP_W-1:0] OP_EMIT     = 4'd7;
  localparam logic [OP_W-1:0] OP_SET_ONE  = 4'd8;

  localparam logic [COND_W-1:0] C_NEVER     = 3'd0;
  localparam logic [COND_W-1:0] C_ALWAYS    = 3'd1;
  localparam logic [COND_W-1:0] C_NO_IN     = 3'd2;
  localparam logic [COND_W-1:0] C_EXP_ZERO  = 3'd3;
  localparam logic [COND_W-1:0] C_EBIT_ZERO = 3'd4;
  localparam logic [COND_W-1:0] C_MUL_BUSY  = 3'd5;
  localparam logic [COND_W-1:0] C_MORE_BITS = 3'd6;
  localparam logic [COND_W-1:0] C_OUT_FULL  = 3'd7;

  localparam logic [DST_W-1:0] DST_NONE = 2'd0;
  localparam logic [DST_W-1:0] DST_BASE = 2'd1;
  localparam logic [DST_W-1:0] DST_ACC  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [COND_W-1:0] cond;
    logic [DST_W-1:0]  dst;
    logic [PC_W-1:0]   tgt;
  } mexp_ctl_t;

  typedef struct packed {
    logic in_valid;
    logic exp_zero;
    logic ebit;
    logic mul_busy;
    logic more_bits;
    logic out_full;
  } mexp_stat_t;

  // When the condition holds the step jumps to tgt, otherwise it falls through.
  function automatic mexp_ctl_t rom_word(input logic [PC_W-1:0] pc);
    mexp_ctl_t w;
    case (pc)
      4'd0:    w = '{OP_ACCEPT,   C_NO_IN,     DST_NONE, 4'd0};
      4'd1:    w = '{OP_NONE,     C_EXP_ZERO,  DST_NONE, 4'd12};
      4'd2:    w = '{OP_MUL_RED,  C_NEVER,     DST_NONE, 4'd0};
      4'd3:    w = '{OP_WAIT,     C_MUL_BUSY,  DST_BASE, 4'd3};
      4'd4:    w = '{OP_NONE,     C_EBIT_ZERO, DST_NONE, 4'd7};
      4'd5:    w = '{OP_MUL_ACC,  C_NEVER,     DST_NONE, 4'd0};
      4'd6:    w = '{OP_WAIT,     C_MUL_BUSY,  DST_ACC,  4'd6};
      4'd7:    w = '{OP_MUL_SQR,  C_NEVER,     DST_NONE, 4'd0};
      4'd8:    w = '{OP_WAIT,     C_MUL_BUSY,  DST_BASE, 4'd8};
      4'd9:    w = '{OP_NEXT_BIT, C_MORE_BITS, DST_NONE, 4'd4};
      4'd10:   w = '{OP_EMIT,     C_OUT_FULL,  DST_NONE, 4'd10};
      4'd11:   w = '{OP_NONE,     C_ALWAYS,    DST_NONE, 4'd0};
      4'd12:   w = '{OP_SET_ONE,  C_ALWAYS,    DST_NONE, 4'd10};
      default: w = '{OP_NONE,     C_ALWAYS,    DST_NONE, 4'd0};
    endcase
    return w;
  endfunction

endpackage

@@ rtl/mexp_mulred.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shift-and-add modular multiplier
// Forms op_a * op_b mod modulus, one multiplier bit per cycle, reducing
// every sum at once. A modulus of zero wraps at 2^WIDTH.
// ----------------------------------------------------------------------------
module mexp_mulred #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [WIDTH-1:0] op_a,
  input  logic [WIDTH-1:0] op_b,
  input  logic [WIDTH-1:0] modulus,
  output logic             busy,
  output logic [WIDTH-1:0] product
);

  localparam int CNT_W = $clog2(WIDTH);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);

  logic [WIDTH-1:0] ma_r, mb_r, macc_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;

  function automatic logic [WIDTH-1:0] add_red(input logic [WIDTH-1:0] x,
                                               input logic [WIDTH-1:0] y,
                                               input logic [WIDTH-1:0] m);
    logic [WIDTH:0]   full;
    logic [WIDTH-1:0] s;
    full = {1'b0, x} + {1'b0, y};
    s    = full[WIDTH-1:0];
    if ((m != '0) && (full[WIDTH] || (s >= m))) begin
      s = s - m;
    end
    return s;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_LAST;
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ma_r   <= op_a;
      mb_r   <= op_b;
      macc_r <= '0;
    end else if (busy_r) begin
      if (ma_r[0]) begin
        macc_r <= add_red(macc_r, mb_r, modulus);
      end
      mb_r <= add_red(mb_r, mb_r, modulus);
      ma_r <= ma_r >> 1;
    end
  end

  assign busy    = busy_r;
  assign product = macc_r;

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("multiplier restarted while busy");
  a_start_load: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> (busy_r && (cnt_r == CNT_LAST))) else $error("multiplier start not loaded");
  a_run_length: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && (cnt_r != '0)) |=> busy_r) else $error("multiplier stopped early");
`endif

endmodule

@@ rtl/mexp_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Exponentiation sequencer
// Step counter over the microprogram with conditional jumps on datapath
// status; presents the control word of the current step.
// ----------------------------------------------------------------------------
module mexp_seq
  import mexp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  mexp_stat_t stat,
  output mexp_ctl_t  ctl
);

  logic [PC_W-1:0] pc_r, pc_nxt;
  mexp_ctl_t       word;
  logic            taken;

  assign word = rom_word(pc_r);

  always_comb begin
    case (word.cond)
      C_NEVER:     taken = 1'b0;
      C_ALWAYS:    taken = 1'b1;
      C_NO_IN:     taken = !stat.in_valid;
      C_EXP_ZERO:  taken = stat.exp_zero;
      C_EBIT_ZERO: taken = !stat.ebit;
      C_MUL_BUSY:  taken = stat.mul_busy;
      C_MORE_BITS: taken = stat.more_bits;
      C_OUT_FULL:  taken = stat.out_full;
      default:     taken = 1'b1;
    endcase
    pc_nxt = taken ? word.tgt : pc_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign ctl = word;

endmodule

@@ rtl/modular_exponentiation_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular exponentiation top level
// Raises each input base to the configured exponent modulo the configured
// modulus with right-to-left square-and-multiply on a shift-add multiplier.
//
// Usage: write the exponent (index 0) and modulus (index 1) through the cfg
// port while the block is idle. Each word on the in_ stream carries one base;
// exactly one word leaves on the out_ stream with the modular power. A zero
// exponent gives 1; a zero modulus wraps at 2^DATA_WIDTH.
// Timing: one base at a time. Every modular product runs in the shared
// multiplier. The base is first reduced by one product, then each of the
// DATA_WIDTH exponent bits costs one squaring, one multiply when the bit is
// set, and two control steps.
// The result sits in an output register; the next base is accepted while
// it waits. If the receiver stalls, the block holds at its emit step.
// Reset sets exponent 0 and modulus 1 and empties the output register.
// ----------------------------------------------------------------------------
module modular_exponentiation_top
  import mexp_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // Fields from bit 0: base.
  input  logic [((DATA_WIDTH + 7) / 8) * 8-1:0] in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // Fields from bit 0: power_result.
  output logic [((DATA_WIDTH + 7) / 8) * 8-1:0] out_tdata,
  input  logic                                 cfg_we,
  input  logic [CFG_IDX_W-1:0]                 cfg_index,
  input  logic [DATA_WIDTH-1:0]                cfg_wdata
);

  localparam int TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;
  localparam int BIT_W   = $clog2(DATA_WIDTH);
  localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(DATA_WIDTH - 1);

  logic [DATA_WIDTH-1:0] exponent_r, modulus_r;
  logic [DATA_WIDTH-1:0] base_r, acc_r, e_r, out_data_r;
  logic [BIT_W-1:0]      bits_r;
  logic                  out_valid_r;

  mexp_ctl_t             ctl;
  mexp_stat_t            stat;
  logic [DATA_WIDTH-1:0] one_mod, mul_a, mul_b, product;
  logic                  mul_start, mul_busy, in_fire, wb_fire, emit_fire, out_full;

  assign one_mod   = {{(DATA_WIDTH-1){1'b0}}, (modulus_r != DATA_WIDTH'(1))};
  assign out_full  = out_valid_r && !out_tready;
  assign in_tready = (ctl.op == OP_ACCEPT);
  assign in_fire   = in_tvalid && in_tready;
  assign wb_fire   = (ctl.op == OP_WAIT) && !mul_busy;
  assign emit_fire = (ctl.op == OP_EMIT) && !out_full;
  assign mul_start = (ctl.op == OP_MUL_RED) || (ctl.op == OP_MUL_ACC) ||
                     (ctl.op == OP_MUL_SQR);

  always_comb begin
    case (ctl.op)
      OP_MUL_RED: begin
        mul_a = base_r;
        mul_b = one_mod;
      end
      OP_MUL_ACC: begin
        mul_a = acc_r;
        mul_b = base_r;
      end
      default: begin
        mul_a = base_r;
        mul_b = base_r;
      end
    endcase
  end

  always_comb begin
    stat.in_valid  = in_tvalid;
    stat.exp_zero  = (e_r == '0);
    stat.ebit      = e_r[0];
    stat.mul_busy  = mul_busy;
    stat.more_bits = (bits_r != '0);
    stat.out_full  = out_full;
  end

  mexp_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctl   (ctl)
  );

  mexp_mulred #(
    .WIDTH (DATA_WIDTH)
  ) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .op_a    (mul_a),
    .op_b    (mul_b),
    .modulus (modulus_r),
    .busy    (mul_busy),
    .product (product)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exponent_r <= '0;
      modulus_r  <= DATA_WIDTH'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_EXPONENT: exponent_r <= cfg_wdata;
        REG_MODULUS:  modulus_r  <= cfg_wdata;
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      base_r <= in_tdata[DATA_WIDTH-1:0];
      e_r    <= exponent_r;
      acc_r  <= one_mod;
      bits_r <= BIT_LAST;
    end
    if (wb_fire && (ctl.dst == DST_BASE)) begin
      base_r <= product;
    end
    if (wb_fire && (ctl.dst == DST_ACC)) begin
      acc_r <= product;
    end
    if (ctl.op == OP_SET_ONE) begin
      acc_r <= DATA_WIDTH'(1);
    end
    if ((ctl.op == OP_NEXT_BIT) && (bits_r != '0)) begin
      e_r    <= e_r >> 1;
      bits_r <= bits_r - 1'b1;
    end
    if (emit_fire) begin
      out_data_r <= acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = TDATA_W'(out_data_r);

endmodule
